// File: rtl/core/cas_pkg.sv
// Shared types and constants for the contact antenna assigner.
// No dependencies; the assigner, selector and checker in rtl/core refer to it by scoped names.
package cas_pkg;

	// Width of the antenna field on the result channel.
	localparam int ANT_W = 2;

	// One assignment result as it travels from the selector to the output register.
	typedef struct packed {
		logic [ANT_W-1:0] antenna;
		logic             reused;
		logic             conflict;
	} result_t;

endpackage

// File: rtl/core/contact_antenna_assigner.sv
// Contact antenna assigner: one antenna per satellite contact, reuse or earliest free.
// A contact passes the input register, then the result register that drives out_valid.
// Throughput: one contact per cycle unless the output stalls, which also stalls the input.
// The choice is a parallel compare over all antenna registers between the input register
// and the result register, state updated at transfer.
// Reset (arst_n low, asynchronous): both stages empty, all antennas unused with end time 0,
// check_enable 0.
module contact_antenna_assigner #(
	parameter int ANTENNAS    = 4,
	parameter int SAT_ID_BITS = 8,
	parameter int TIME_BITS   = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_wr_en,
	input  logic                       cfg_wr_data,
	// contact input
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       first_of_batch,
	input  logic [SAT_ID_BITS-1:0]     satellite,
	input  logic [TIME_BITS-1:0]       start_time,
	input  logic [TIME_BITS-1:0]       end_time,
	// assignment output
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [cas_pkg::ANT_W-1:0]  antenna,
	output logic                       reused,
	output logic                       conflict
);

	logic check_enable_q;

	// Input stage: holds one accepted contact while its antenna is chosen.
	logic                   valid_s1;
	logic                   first_s1;
	logic [SAT_ID_BITS-1:0] sat_s1;
	logic [TIME_BITS-1:0]   start_s1;
	logic [TIME_BITS-1:0]   end_s1;

	// Result register.
	logic                   out_valid_q;
	cas_pkg::result_t       result_q;

	logic                   in_xfer;
	logic                   advance;
	logic [ANTENNAS-1:0]    choice_oh;
	cas_pkg::result_t       result;
	logic [TIME_BITS-1:0]   last_end [ANTENNAS];
	logic [SAT_ID_BITS-1:0] last_sat [ANTENNAS];
	logic [ANTENNAS-1:0]    used;

	// Advance the input stage when the result register is empty or drains this cycle;
	// the bank is written on the same edge so the next contact sees the new state.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			check_enable_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: capture on transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			first_s1 <= first_of_batch;
			sat_s1   <= satellite;
			start_s1 <= start_time;
			end_s1   <= end_time;
		end
		if (advance) begin
			result_q <= result;
		end
	end

	cas_antenna_bank #(
		.ANTENNAS    (ANTENNAS),
		.SAT_ID_BITS (SAT_ID_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (advance),
		.clear     (first_s1),
		.choice_oh (choice_oh),
		.satellite (sat_s1),
		.end_time  (end_s1),
		.last_end  (last_end),
		.last_sat  (last_sat),
		.used      (used)
	);

	cas_selector #(
		.ANTENNAS    (ANTENNAS),
		.SAT_ID_BITS (SAT_ID_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_sel (
		.first_of_batch (first_s1),
		.satellite      (sat_s1),
		.start_time     (start_s1),
		.check_enable   (check_enable_q),
		.last_end       (last_end),
		.last_sat       (last_sat),
		.used           (used),
		.choice_oh      (choice_oh),
		.result         (result)
	);

	assign out_valid = out_valid_q;
	assign antenna   = result_q.antenna;
	assign reused    = result_q.reused;
	assign conflict  = result_q.conflict;

endmodule

// File: rtl/core/cas_antenna_bank.sv
// Per-antenna state registers: last end time, last satellite, used flag.
// Depends on nothing but the clock and reset; written by the top level on each transfer.
module cas_antenna_bank #(
	parameter int ANTENNAS    = 4,
	parameter int SAT_ID_BITS = 8,
	parameter int TIME_BITS   = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic                   clear,
	input  logic [ANTENNAS-1:0]    choice_oh,
	input  logic [SAT_ID_BITS-1:0] satellite,
	input  logic [TIME_BITS-1:0]   end_time,
	output logic [TIME_BITS-1:0]   last_end [ANTENNAS],
	output logic [SAT_ID_BITS-1:0] last_sat [ANTENNAS],
	output logic [ANTENNAS-1:0]    used
);

	logic [TIME_BITS-1:0]   last_end_q [ANTENNAS];
	logic [SAT_ID_BITS-1:0] last_sat_q [ANTENNAS];
	logic [ANTENNAS-1:0]    used_q;

	// End times and used flags reset to zero; an unused antenna counts as ending at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int a = 0; a < ANTENNAS; a++) begin
				last_end_q[a] <= '0;
			end
		end else if (wr_en) begin
			for (int a = 0; a < ANTENNAS; a++) begin
				if (choice_oh[a]) begin
					used_q[a]     <= 1'b1;
					last_end_q[a] <= end_time;
				end else if (clear) begin
					used_q[a]     <= 1'b0;
					last_end_q[a] <= '0;
				end
			end
		end
	end

	// Satellite ids are only read behind the used flag, so they carry no reset.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int a = 0; a < ANTENNAS; a++) begin
				if (choice_oh[a]) begin
					last_sat_q[a] <= satellite;
				end
			end
		end
	end

	assign last_end = last_end_q;
	assign last_sat = last_sat_q;
	assign used     = used_q;

endmodule

// File: rtl/core/cas_selector.sv
// Combinational antenna choice: satellite match first, else earliest end time.
// Depends on cas_pkg for the result type; reads the state held in cas_antenna_bank.
module cas_selector #(
	parameter int ANTENNAS    = 4,
	parameter int SAT_ID_BITS = 8,
	parameter int TIME_BITS   = 32
) (
	input  logic                   first_of_batch,
	input  logic [SAT_ID_BITS-1:0] satellite,
	input  logic [TIME_BITS-1:0]   start_time,
	input  logic                   check_enable,
	input  logic [TIME_BITS-1:0]   last_end [ANTENNAS],
	input  logic [SAT_ID_BITS-1:0] last_sat [ANTENNAS],
	input  logic [ANTENNAS-1:0]    used,
	output logic [ANTENNAS-1:0]    choice_oh,
	output cas_pkg::result_t       result
);

	localparam int AW = cas_pkg::ANT_W;

	logic [TIME_BITS-1:0] end_eff [ANTENNAS];
	logic [ANTENNAS-1:0]  used_eff;
	logic [ANTENNAS-1:0]  match;
	logic [ANTENNAS-1:0]  match_oh;
	logic [ANTENNAS-1:0]  min_oh;
	logic [ANTENNAS-1:0]  late;
	logic                 any_match;
	logic [AW-1:0]        ant;

	// A batch start sees every antenna as cleared.
	always_comb begin
		for (int a = 0; a < ANTENNAS; a++) begin
			end_eff[a]  = first_of_batch ? '0 : last_end[a];
			used_eff[a] = used[a] & ~first_of_batch;
			match[a]    = used_eff[a] && (last_sat[a] == satellite);
			late[a]     = end_eff[a] > start_time;
		end
	end

	// Lowest matching antenna.
	assign match_oh  = match & (~match + ANTENNAS'(1));
	assign any_match = |match;

	// Pairwise compare: strictly below every lower index, not above any higher one.
	always_comb begin
		for (int a = 0; a < ANTENNAS; a++) begin
			min_oh[a] = 1'b1;
			for (int b = 0; b < ANTENNAS; b++) begin
				if (b < a) begin
					min_oh[a] = min_oh[a] & (end_eff[a] < end_eff[b]);
				end else if (b > a) begin
					min_oh[a] = min_oh[a] & (end_eff[a] <= end_eff[b]);
				end
			end
		end
	end

	assign choice_oh = any_match ? match_oh : min_oh;

	always_comb begin
		ant = '0;
		for (int a = 0; a < ANTENNAS; a++) begin
			if (choice_oh[a]) begin
				ant = ant | AW'(a);
			end
		end
	end

	assign result.antenna  = ant;
	assign result.reused   = any_match;
	assign result.conflict = check_enable & ~any_match & (|(min_oh & used_eff & late));

endmodule

// File: rtl/core/cas_checker.sv
// Port-level assertions for contact_antenna_assigner, attached by the bind below.
// Depends on cas_pkg for the antenna field width.
module cas_checker #(
	parameter int ANTENNAS = 4
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [cas_pkg::ANT_W-1:0] antenna,
	input logic                      reused,
	input logic                      conflict
);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(antenna) && $stable(reused)
			&& $stable(conflict))
		else $error("stalled result changed");

	// Input backpressure only when a result is waiting and not taken.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// A reused antenna never reports a conflict.
	a_reuse_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reused |-> !conflict)
		else $error("conflict on reused antenna");

	// Antenna index stays inside the bank.
	a_ant_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ANTENNAS >= 4) || (antenna < ANTENNAS))
		else $error("antenna index out of range");

endmodule

bind contact_antenna_assigner cas_checker #(
	.ANTENNAS (ANTENNAS)
) u_cas_checker (.*);

// File: dv/antenna_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the contact antenna assigner: predicts antenna choices and checks results.
// Depends on cas_pkg for the result type.
package antenna_scoreboard_pkg;

	class antenna_scoreboard;
		localparam int ANTENNAS = 4;
		localparam int SAT_W    = 8;
		localparam int TIME_W   = 32;

		logic [TIME_W-1:0] end_at[ANTENNAS];
		logic [SAT_W-1:0]  sat_at[ANTENNAS];
		bit                busy[ANTENNAS];
		bit                check_en;
		cas_pkg::result_t  expected_q[$];
		int                errors;

		function new();
			clear_antennas();
			check_en = 1'b0;
			errors   = 0;
		endfunction

		function void clear_antennas();
			for (int a = 0; a < ANTENNAS; a++) begin
				end_at[a] = '0;
				sat_at[a] = '0;
				busy[a]   = 1'b0;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Work out the assignment for one accepted contact and queue it.
		function void note_contact(bit fob, logic [SAT_W-1:0] sat, logic [TIME_W-1:0] st,
			logic [TIME_W-1:0] en);
			int               pick;
			bit               found;
			cas_pkg::result_t res;
			pick  = 0;
			found = 1'b0;
			res   = '0;
			if (fob)
				clear_antennas();
			for (int a = 0; a < ANTENNAS; a++) begin
				if (!found && busy[a] && sat_at[a] == sat) begin
					pick  = a;
					found = 1'b1;
				end
			end
			if (!found) begin
				for (int a = 1; a < ANTENNAS; a++) begin
					if (end_at[a] < end_at[pick])
						pick = a;
				end
				res.conflict = check_en && busy[pick] && (end_at[pick] > st);
			end
			res.reused   = found;
			res.antenna  = pick[cas_pkg::ANT_W-1:0];
			end_at[pick] = en;
			sat_at[pick] = sat;
			busy[pick]   = 1'b1;
			expected_q   = {expected_q, res};
		endfunction

		function void check_result(cas_pkg::result_t got);
			cas_pkg::result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: antenna %0d reused %0d conflict %0d",
					$time, got.antenna, got.reused, got.conflict);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.antenna !== want.antenna) begin
				$display("%0t: antenna expected %0d actual %0d", $time, want.antenna, got.antenna);
				errors++;
			end
			if (got.reused !== want.reused) begin
				$display("%0t: reused expected %0d actual %0d", $time, want.reused, got.reused);
				errors++;
			end
			if (got.conflict !== want.conflict) begin
				$display("%0t: conflict expected %0d actual %0d", $time, want.conflict,
					got.conflict);
				errors++;
			end
		endfunction
	endclass

endpackage

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench for contact_antenna_assigner: clock, reset, stimulus and checking.
// Depends on cas_pkg and antenna_scoreboard_pkg.
module testbench;

	localparam int STALL_LIMIT = 4000;  // cycles without any transfer before giving up
	localparam int RANDOM_ITEMS = 800;

	logic                       clk            = 1'b0;
	logic                       arst_n         = 1'b0;
	logic                       cfg_wr_en      = 1'b0;
	logic                       cfg_wr_data    = 1'b0;
	logic                       in_valid       = 1'b0;
	logic                       in_ready;
	logic                       first_of_batch = 1'b0;
	logic [7:0]                 satellite      = '0;
	logic [31:0]                start_time     = '0;
	logic [31:0]                end_time       = '0;
	logic                       out_valid;
	logic                       out_ready      = 1'b0;
	logic [cas_pkg::ANT_W-1:0]  antenna;
	logic                       reused;
	logic                       conflict;

	antenna_scoreboard_pkg::antenna_scoreboard sb = new();
	int idle_pct    = 12;
	int items_sent  = 0;
	int stall_count = 0;

	always #2 clk = ~clk;

	contact_antenna_assigner DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_of_batch (first_of_batch),
		.satellite      (satellite),
		.start_time     (start_time),
		.end_time       (end_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.antenna        (antenna),
		.reused         (reused),
		.conflict       (conflict)
	);

	// Receiver: drop ready now and then; idle_pct goes to zero during the no-idle stretch.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct);
	end

	// Monitor: sample at the edge, so both sides see pre-edge values of every signal.
	// Note the input transfer first, then check the output transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_contact(first_of_batch, satellite, start_time, end_time);
			if (out_valid && out_ready)
				sb.check_result('{antenna: antenna, reused: reused, conflict: conflict});
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Present one contact and hold it until the transfer. Valid stays high on return,
	// so back-to-back contacts keep it up; an idle gap lowers it first.
	task automatic send_contact(input bit fob, input logic [7:0] sat, input logic [31:0] st,
		input logic [31:0] en);
		idle_pct = (items_sent >= 300 && items_sent < 450) ? 0 : 12;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct * 3)
				@(posedge clk);
		end
		in_valid       <= 1'b1;
		first_of_batch <= fob;
		satellite      <= sat;
		start_time     <= st;
		end_time       <= en;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Hold off the sender until every expected result has been accepted.
	// Wait for a clock edge first so the last input transfer is already noted.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Write the checking register with the block idle, and mirror it in the predictor.
	task automatic set_check_enable(input bit v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sb.check_en = v;
	endtask

	// A realistic pass: clear on the first contact, a small pool of satellites,
	// starts mostly nondecreasing. Occasionally break the order or the duration.
	task automatic run_batch();
		int          len;
		int          pool;
		logic [7:0]  sat_base;
		logic [7:0]  sat;
		logic [31:0] cursor;
		logic [31:0] st;
		logic [31:0] en;
		len      = $urandom_range(24, 4);
		pool     = $urandom_range(8, 1);
		sat_base = 8'($urandom_range(255));
		cursor   = $urandom;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0) begin
				st = cursor - $urandom_range(100, 1);
			end else begin
				cursor = cursor + $urandom_range(60);
				st     = cursor;
			end
			if ($urandom_range(19) == 0)
				en = $urandom;
			else
				en = st + $urandom_range(250);
			sat = 8'(sat_base + $urandom_range(pool - 1));
			send_contact(i == 0, sat, st, en);
		end
	endtask

	// Unstructured contacts: any satellite, any times, random clears.
	task automatic run_noise();
		int len;
		len = $urandom_range(6, 1);
		for (int i = 0; i < len; i++)
			send_contact(1'($urandom_range(1)), 8'($urandom_range(255)), $urandom, $urandom);
	endtask

	initial begin
		// Hold reset, then release it on a clock edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Checking off at reset: unused antennas must not match satellite 0,
		// ties go to the lowest index, extremes of every field.
		send_contact(1'b0, 8'd0,   32'd0,          32'd0);
		send_contact(1'b0, 8'd0,   32'd0,          32'd0);
		send_contact(1'b0, 8'd255, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
		send_contact(1'b0, 8'd1,   32'd10,         32'd5);

		// Checking on: overlaps, the equal-end boundary and reuse despite overlap.
		set_check_enable(1'b1);
		send_contact(1'b1, 8'd1,   32'd100,        32'd200);
		send_contact(1'b0, 8'd2,   32'd110,        32'd300);
		send_contact(1'b0, 8'd3,   32'd120,        32'd150);
		send_contact(1'b0, 8'd4,   32'd130,        32'd400);
		send_contact(1'b0, 8'd5,   32'd140,        32'd500);
		send_contact(1'b0, 8'd6,   32'd200,        32'd210);
		send_contact(1'b0, 8'd1,   32'd205,        32'd250);
		send_contact(1'b0, 8'd4,   32'd220,        32'd230);
		send_contact(1'b1, 8'd0,   32'd0,          32'hFFFF_FFFF);
		send_contact(1'b0, 8'd0,   32'd0,          32'd0);
		send_contact(1'b0, 8'd255, 32'hFFFF_FFFF,  32'd0);
		send_contact(1'b0, 8'd128, 32'h8000_0000,  32'h7FFF_FFFF);
		send_contact(1'b0, 8'd7,   32'd1,          32'hFFFF_FFFE);
		send_contact(1'b0, 8'd9,   32'hFFFF_FFFF,  32'd1);
		send_contact(1'b0, 8'd170, 32'd50,         32'h5555_5555);

		// Checking off again: overlapping contacts must raise no conflict.
		set_check_enable(1'b0);
		send_contact(1'b1, 8'd10,  32'd100,        32'd900);
		send_contact(1'b0, 8'd11,  32'd101,        32'd900);
		send_contact(1'b0, 8'd12,  32'd102,        32'd900);
		send_contact(1'b0, 8'd13,  32'd103,        32'd900);
		send_contact(1'b0, 8'd14,  32'd104,        32'd900);

		// Random phases, alternating the checking setting between them.
		for (int phase = 0; phase < 4; phase++) begin
			set_check_enable(phase % 2 == 0);
			while (items_sent < 25 + (phase + 1) * (RANDOM_ITEMS / 4)) begin
				if ($urandom_range(99) < 80)
					run_batch();
				else
					run_noise();
				if (phase == 2 && sb.pending() != 0 && $urandom_range(39) == 0)
					drain_results();
			end
		end

		// Let the pipeline empty, then watch for stray results.
		drain_results();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule

// File: files.f
rtl/core/cas_pkg.sv
rtl/core/cas_antenna_bank.sv
rtl/core/cas_selector.sv
rtl/core/contact_antenna_assigner.sv
rtl/core/cas_checker.sv
dv/antenna_scoreboard_pkg.sv
dv/testbench.sv
